/* hw/rtl/tjl_pkg.sv */
// Shared widths, constants, codes and the CORDIC arctangent table for the
// three-joint leg inverse kinematics pipeline. No dependencies.
`timescale 1ns / 1ps

package tjl_pkg;

  // Port field widths
  localparam int POS_W       = 16;
  localparam int DEG_W       = 10;
  localparam int LEN_CFG_W   = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int COXA_OUT_W  = 15;
  localparam int JOINT_OUT_W = 17;
  localparam int STATUS_W    = 2;

  // Internal datapath widths
  localparam int CW        = 34;  // CORDIC x/y
  localparam int AW        = 26;  // Q16 degrees
  localparam int VW        = 28;  // unwrapped coxa angle, Q16 degrees
  localparam int MAG_W     = 32;  // scaled CORDIC magnitude
  localparam int GAIN_W    = 24;
  localparam int DW        = 24;  // distance, 1/256 mm
  localparam int LEN_W     = 20;  // link length, 1/256 mm
  localparam int PW        = 50;  // law of cosines terms
  localparam int RW        = 40;  // output rounding
  localparam int POS_SHIFT = 12;
  localparam int TW        = 32;  // signed acos argument, Q30
  localparam int TM_W      = 31;  // its magnitude
  localparam int NW        = 61;  // 1 - t^2, Q60
  localparam int SQ_W      = 62;
  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 31;
  localparam int RT_MSB     = 2 * (SQRT_STEPS - 1);
  localparam int ATAN_LEN   = 24;

  localparam logic [GAIN_W-1:0]   GAIN_Q24   = 24'd10187830;
  localparam logic signed [AW-1:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [VW-1:0] DEG180_Q16 = 28'sd11796480;
  localparam logic signed [VW-1:0] DEG360_Q16 = 28'sd23592960;
  localparam logic [TM_W-1:0]     UNIT_Q30   = TM_W'(1) << DIV_STEPS;
  localparam logic [NW-1:0]       UNIT_Q60   = NW'(1) << RT_MSB;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COXA_LEN  = 3'd0,
    CFG_FEMUR_LEN = 3'd1,
    CFG_TIBIA_LEN = 3'd2,
    CFG_FEMUR_ZERO = 3'd3,
    CFG_TIBIA_ZERO = 3'd4
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_REACH = 2'd1,
    ST_TOO_CLOSE    = 2'd2
  } status_e;

  typedef struct packed {
    logic                  clamp;
    logic signed [AW-1:0]  angle;
  } acos_res_t;

  function automatic logic signed [AW-1:0] atan_q16(input int idx);
    logic signed [AW-1:0] a;
    case (idx)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/tjl_in_if.sv */
// Input channel: one foot target per beat.
// Depends on tjl_pkg for field widths.
`timescale 1ns / 1ps

interface tjl_in_if import tjl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  target_x;
  logic signed [POS_W-1:0]  target_y;
  logic signed [POS_W-1:0]  target_z;
  logic signed [DEG_W-1:0]  coxa_mount_deg;

  modport source (output valid, target_x, target_y, target_z, coxa_mount_deg,
                  input ready);
  modport sink   (input valid, target_x, target_y, target_z, coxa_mount_deg,
                  output ready);
endinterface

/* hw/rtl/tjl_out_if.sv */
// Output channel: three joint angles and a status code per beat.
// Depends on tjl_pkg for field widths.
`timescale 1ns / 1ps

interface tjl_out_if import tjl_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [COXA_OUT_W-1:0]   coxa_angle;
  logic signed [JOINT_OUT_W-1:0]  femur_angle;
  logic signed [JOINT_OUT_W-1:0]  tibia_angle;
  logic [STATUS_W-1:0]            status;

  modport source (output valid, coxa_angle, femur_angle, tibia_angle, status,
                  input ready);
  modport sink   (input valid, coxa_angle, femur_angle, tibia_angle, status,
                  output ready);
endinterface

/* hw/rtl/tjl_cordic.sv */
// Pipelined vectoring CORDIC, one rotation per stage, angle in Q16 degrees.
// Depends on tjl_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module tjl_cordic import tjl_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SB_W  = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [CW-1:0]  x_i,
  input  logic signed [CW-1:0]  y_i,
  input  logic [SB_W-1:0]       sb_i,
  output logic                  valid_o,
  output logic signed [CW-1:0]  x_o,
  output logic signed [AW-1:0]  acc_o,
  output logic [SB_W-1:0]       sb_o
);

  logic                 v_q   [STEPS+1];
  logic signed [CW-1:0] x_q   [STEPS+1];
  logic signed [CW-1:0] y_q   [STEPS+1];
  logic signed [AW-1:0] acc_q [STEPS+1];
  logic [SB_W-1:0]      sb_q  [STEPS+1];
  logic signed [CW-1:0] x_d   [STEPS+1];
  logic signed [CW-1:0] y_d   [STEPS+1];
  logic signed [AW-1:0] acc_d [STEPS+1];

  always_comb begin
    // fold the left half plane onto the right by a quarter turn
    x_d[0]   = x_i;
    y_d[0]   = y_i;
    acc_d[0] = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_d[0]   = y_i;
        y_d[0]   = -x_i;
        acc_d[0] = DEG90_Q16;
      end else begin
        x_d[0]   = -y_i;
        y_d[0]   = x_i;
        acc_d[0] = -DEG90_Q16;
      end
    end
    for (int k = 0; k < STEPS; k++) begin
      if (y_q[k] > 0) begin
        x_d[k+1]   = x_q[k] + (y_q[k] >>> k);
        y_d[k+1]   = y_q[k] - (x_q[k] >>> k);
        acc_d[k+1] = acc_q[k] + atan_q16(k);
      end else begin
        x_d[k+1]   = x_q[k] - (y_q[k] >>> k);
        y_d[k+1]   = y_q[k] + (x_q[k] >>> k);
        acc_d[k+1] = acc_q[k] - atan_q16(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= STEPS; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 0; k < STEPS; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int k = 0; k <= STEPS; k++) begin
        x_q[k]   <= x_d[k];
        y_q[k]   <= y_d[k];
        acc_q[k] <= acc_d[k];
      end
      for (int k = 0; k < STEPS; k++) sb_q[k+1] <= sb_q[k];
    end
  end

  assign valid_o = v_q[STEPS];
  assign x_o     = x_q[STEPS];
  assign acc_o   = acc_q[STEPS];
  assign sb_o    = sb_q[STEPS];

endmodule

/* hw/rtl/tjl_acos.sv */
// Pipelined acos(p/q): restoring divide to Q30, square, bit-serial integer
// square root per stage, then atan2 by CORDIC. Depends on tjl_pkg, tjl_cordic.
`timescale 1ns / 1ps

module tjl_acos import tjl_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SB_W  = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [PW-1:0]  p_i,
  input  logic [PW-1:0]         q_i,
  input  logic [SB_W-1:0]       sb_i,
  output logic                  valid_o,
  output acos_res_t             res_o,
  output logic [SB_W-1:0]       sb_o
);

  // divider section
  logic                   p_neg;
  logic [PW-1:0]          p_abs;
  logic                   dv_q  [DIV_STEPS+1];
  logic [PW-1:0]          rem_q [DIV_STEPS+1];
  logic [PW-1:0]          rem_d [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]   quo_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]   quo_d [DIV_STEPS+1];
  logic [PW-1:0]          dq_q  [DIV_STEPS+1];
  logic                   sgn_q [DIV_STEPS+1];
  logic                   frc_q [DIV_STEPS+1];
  logic                   dcl_q [DIV_STEPS+1];
  logic [SB_W-1:0]        dsb_q [DIV_STEPS+1];
  logic [PW:0]            sh_w  [DIV_STEPS];

  // argument stage
  logic                   tv_q;
  logic signed [TW-1:0]   t_q;
  logic [TM_W-1:0]        tm_q;
  logic                   tcl_q;
  logic [SB_W-1:0]        tsb_q;
  logic [TM_W-1:0]        tm_d;
  logic [SQ_W-1:0]        sqr;

  // square root section
  logic                   sv_q  [SQRT_STEPS+1];
  logic [NW-1:0]          n_q   [SQRT_STEPS+1];
  logic [NW-1:0]          n_d   [SQRT_STEPS+1];
  logic [SQ_W-1:0]        r_q   [SQRT_STEPS+1];
  logic [SQ_W-1:0]        r_d   [SQRT_STEPS+1];
  logic signed [TW-1:0]   st_q  [SQRT_STEPS+1];
  logic                   scl_q [SQRT_STEPS+1];
  logic [SB_W-1:0]        ssb_q [SQRT_STEPS+1];
  logic [SQ_W-1:0]        bit_w [SQRT_STEPS];
  logic [SQ_W-1:0]        trl_w [SQRT_STEPS];

  logic [TM_W-1:0]        root;
  logic [SB_W:0]          csb;
  logic signed [AW-1:0]   c_ang;

  assign p_neg = (p_i < 0);
  assign p_abs = p_neg ? PW'(-p_i) : PW'(p_i);

  always_comb begin
    rem_d[0] = p_abs;
    quo_d[0] = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh_w[k] = {rem_q[k], 1'b0};
      if (sh_w[k] >= {1'b0, dq_q[k]}) begin
        rem_d[k+1] = PW'(sh_w[k] - {1'b0, dq_q[k]});
        quo_d[k+1] = {quo_q[k][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_d[k+1] = sh_w[k][PW-1:0];
        quo_d[k+1] = {quo_q[k][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // a ratio of one or more, or a zero denominator, pins t to +-1
  assign tm_d = frc_q[DIV_STEPS] ? UNIT_Q30 : {1'b0, quo_q[DIV_STEPS]};
  assign sqr  = tm_q * tm_q;

  always_comb begin
    n_d[0] = UNIT_Q60 - sqr[NW-1:0];
    r_d[0] = '0;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bit_w[j] = SQ_W'(1) << (RT_MSB - 2 * j);
      trl_w[j] = r_q[j] + bit_w[j];
      if ({1'b0, n_q[j]} >= trl_w[j]) begin
        n_d[j+1] = n_q[j] - trl_w[j][NW-1:0];
        r_d[j+1] = (r_q[j] >> 1) + bit_w[j];
      end else begin
        n_d[j+1] = n_q[j];
        r_d[j+1] = r_q[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) dv_q[k] <= 1'b0;
      tv_q <= 1'b0;
      for (int j = 0; j <= SQRT_STEPS; j++) sv_q[j] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= valid_i;
      for (int k = 0; k < DIV_STEPS; k++) dv_q[k+1] <= dv_q[k];
      tv_q    <= dv_q[DIV_STEPS];
      sv_q[0] <= tv_q;
      for (int j = 0; j < SQRT_STEPS; j++) sv_q[j+1] <= sv_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_q[0]  <= q_i;
      sgn_q[0] <= p_neg;
      frc_q[0] <= (q_i == '0) || (p_abs >= q_i);
      dcl_q[0] <= (q_i == '0) || (p_abs > q_i);
      dsb_q[0] <= sb_i;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        dq_q[k+1]  <= dq_q[k];
        sgn_q[k+1] <= sgn_q[k];
        frc_q[k+1] <= frc_q[k];
        dcl_q[k+1] <= dcl_q[k];
        dsb_q[k+1] <= dsb_q[k];
      end

      tm_q  <= tm_d;
      t_q   <= sgn_q[DIV_STEPS] ? -$signed({1'b0, tm_d}) : $signed({1'b0, tm_d});
      tcl_q <= dcl_q[DIV_STEPS];
      tsb_q <= dsb_q[DIV_STEPS];

      st_q[0]  <= t_q;
      scl_q[0] <= tcl_q;
      ssb_q[0] <= tsb_q;
      for (int j = 0; j <= SQRT_STEPS; j++) begin
        n_q[j] <= n_d[j];
        r_q[j] <= r_d[j];
      end
      for (int j = 0; j < SQRT_STEPS; j++) begin
        st_q[j+1]  <= st_q[j];
        scl_q[j+1] <= scl_q[j];
        ssb_q[j+1] <= ssb_q[j];
      end
    end
  end

  assign root = r_q[SQRT_STEPS][TM_W-1:0];

  tjl_cordic #(
    .STEPS (STEPS),
    .SB_W  (SB_W + 1)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (sv_q[SQRT_STEPS]),
    .x_i     (CW'(st_q[SQRT_STEPS])),
    .y_i     ($signed({{(CW-TM_W){1'b0}}, root})),
    .sb_i    ({scl_q[SQRT_STEPS], ssb_q[SQRT_STEPS]}),
    .valid_o (valid_o),
    .x_o     (),
    .acc_o   (c_ang),
    .sb_o    (csb)
  );

  assign res_o = {csb[SB_W], c_ang};
  assign sb_o  = csb[SB_W-1:0];

endmodule

/* hw/rtl/three_joint_leg_inverse_kinematics.sv */
// Top level of the leg inverse kinematics pipeline: configuration registers,
// glue stages, two CORDICs and two acos units. Depends on tjl_pkg,
// tjl_in_if, tjl_out_if, tjl_cordic, tjl_acos.
//
// Usage:
//   tgt_i carries one foot target (x, y, z in 1/16 mm) and the leg mounting
//   angle per beat; res_o returns the coxa, femur and tibia angles in
//   1/2^ANGLE_FRAC_BITS degree and a status code (ok, out of reach, too
//   close) for every beat, in order.
//   Link lengths and servo zero offsets are written through cfg_we_i,
//   cfg_idx_i and cfg_data_i, which the user must do only while no beat is
//   in flight; the block does not enforce this. Throughput: one beat per
//   cycle unless res_o stalls. Each beat passes the three CORDIC pipelines
//   in series with the 30-stage divider and 31-stage square root.
//   The whole pipeline, output register included, advances together: when
//   res_o holds a beat that is not taken, every stage holds, empty slots
//   too, and tgt_i.ready drops until the beat is taken.
//   Reset clears all valid bits and all configuration registers to zero.
`timescale 1ns / 1ps

module three_joint_leg_inverse_kinematics import tjl_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  tjl_in_if.sink               tgt_i,
  tjl_out_if.source            res_o
);

  localparam int RND_SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (RND_SHIFT - 1);

  function automatic logic signed [CW-1:0] pos_scale(input logic signed [POS_W-1:0] p);
    return CW'(p) <<< POS_SHIFT;
  endfunction

  function automatic logic [MAG_W-1:0] gain_mag(input logic signed [CW-1:0] x);
    logic [MAG_W+GAIN_W-1:0] prod;
    prod = (x < 0) ? '0 : x[MAG_W-1:0] * GAIN_Q24;
    return prod[MAG_W+GAIN_W-1:GAIN_W];
  endfunction

  function automatic logic signed [AW-1:0] wrap180(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] w;
    w = v;
    if (w > DEG180_Q16) w = w - DEG360_Q16;
    if (w > DEG180_Q16) w = w - DEG360_Q16;
    if (w <= -DEG180_Q16) w = w + DEG360_Q16;
    if (w <= -DEG180_Q16) w = w + DEG360_Q16;
    return AW'(w);
  endfunction

  function automatic logic signed [RW-1:0] round_q16(input logic signed [RW-1:0] v);
    return (v + RND_HALF) >>> RND_SHIFT;
  endfunction

  // configuration
  logic [LEN_CFG_W-1:0]     coxa_len_q, femur_len_q, tibia_len_q;
  logic signed [DEG_W-1:0]  femur_zero_q, tibia_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coxa_len_q   <= '0;
      femur_len_q  <= '0;
      tibia_len_q  <= '0;
      femur_zero_q <= '0;
      tibia_zero_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COXA_LEN:   coxa_len_q   <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_FEMUR_LEN:  femur_len_q  <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_TIBIA_LEN:  tibia_len_q  <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_FEMUR_ZERO: femur_zero_q <= $signed(cfg_data_i[DEG_W-1:0]);
        CFG_TIBIA_ZERO: tibia_zero_q <= $signed(cfg_data_i[DEG_W-1:0]);
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] a_len, b_len;
  assign a_len = {tibia_len_q, 8'b0};
  assign b_len = {femur_len_q, 8'b0};

  // global advance
  logic en;
  logic out_v_q;
  assign en          = !out_v_q || res_o.ready;
  assign tgt_i.ready = en;

  // first CORDIC: horizontal plane, coxa angle and reach
  localparam int SB1_W = POS_W + DEG_W + 1;
  logic                     c1_v;
  logic signed [CW-1:0]     c1_x;
  logic signed [AW-1:0]     c1_acc;
  logic [SB1_W-1:0]         c1_sb;
  logic signed [POS_W-1:0]  c1_y;
  logic signed [DEG_W-1:0]  c1_th;
  logic                     c1_zero;

  tjl_cordic #(
    .STEPS (CORDIC_STEPS),
    .SB_W  (SB1_W)
  ) u_cordic_coxa (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tgt_i.valid),
    .x_i     (pos_scale(tgt_i.target_x)),
    .y_i     (pos_scale(tgt_i.target_z)),
    .sb_i    ({tgt_i.target_y, tgt_i.coxa_mount_deg,
               (tgt_i.target_x == '0) && (tgt_i.target_z == '0)}),
    .valid_o (c1_v),
    .x_o     (c1_x),
    .acc_o   (c1_acc),
    .sb_o    (c1_sb)
  );

  assign {c1_y, c1_th, c1_zero} = c1_sb;

  // stage B: gain correction, mounting offset
  logic                     b_v_q;
  logic [MAG_W-1:0]         b_mag_q;
  logic signed [VW-1:0]     b_ang_q;
  logic signed [POS_W-1:0]  b_y_q;
  logic                     b_zero_q;
  // stage B2: remove coxa length
  logic                     b2_v_q;
  logic signed [CW-1:0]     b2_u_q;
  logic signed [CW-1:0]     b2_y_q;
  logic signed [VW-1:0]     b2_ang_q;
  logic                     b2_zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_mag_q   <= gain_mag(c1_x);
      b_ang_q   <= VW'(c1_acc) - (VW'(c1_th) <<< 16);
      b_y_q     <= c1_y;
      b_zero_q  <= c1_zero;
      b2_u_q    <= $signed({{(CW-MAG_W){1'b0}}, b_mag_q})
                   - $signed({{(CW-LEN_CFG_W-16){1'b0}}, coxa_len_q, 16'b0});
      b2_y_q    <= pos_scale(b_y_q);
      b2_ang_q  <= b_ang_q;
      b2_zero_q <= b_zero_q;
    end
  end

  // second CORDIC: vertical plane, distance and elevation
  localparam int SB2_W = VW + 1;
  logic                  c2_v;
  logic signed [CW-1:0]  c2_x;
  logic signed [AW-1:0]  c2_acc;
  logic [SB2_W-1:0]      c2_sb;
  logic signed [VW-1:0]  c2_ang;
  logic                  c2_zero;

  tjl_cordic #(
    .STEPS (CORDIC_STEPS),
    .SB_W  (SB2_W)
  ) u_cordic_reach (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b2_v_q),
    .x_i     (b2_u_q),
    .y_i     (b2_y_q),
    .sb_i    ({b2_ang_q, b2_zero_q}),
    .valid_o (c2_v),
    .x_o     (c2_x),
    .acc_o   (c2_acc),
    .sb_o    (c2_sb)
  );

  assign {c2_ang, c2_zero} = c2_sb;

  // stage C: magnitude, coxa wrap; C2: distance, reach check
  logic                  c_v_q, c2s_v_q, d_v_q, e_v_q;
  logic [MAG_W-1:0]      c_m2_q;
  logic signed [AW-1:0]  c_fi_q, c2s_fi_q, d_fi_q, e_fi_q;
  logic signed [AW-1:0]  c_coxa_q, c2s_coxa_q, d_coxa_q, e_coxa_q;
  logic [MAG_W:0]        c_rnd;
  logic [DW-1:0]         c2s_d_q;
  logic                  c2s_oor_q, d_oor_q, e_oor_q;
  logic [2*DW-1:0]       d_dd_q;
  logic [2*LEN_W-1:0]    d_aa_q, d_bb_q, d_ab_q;
  logic [DW+LEN_W-1:0]   d_bd_q;
  logic signed [PW-1:0]  e_pa_q, e_pg_q;
  logic [PW-1:0]         e_qa_q, e_qg_q;

  assign c_rnd = {1'b0, c_m2_q} + (MAG_W+1)'(128);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_m2_q   <= gain_mag(c2_x);
      c_fi_q   <= c2_acc;
      c_coxa_q <= c2_zero ? '0 : wrap180(c2_ang);

      c2s_d_q    <= c_rnd[DW+7:8];
      c2s_oor_q  <= c_rnd[DW+7:8] > DW'({1'b0, a_len} + {1'b0, b_len});
      c2s_fi_q   <= c_fi_q;
      c2s_coxa_q <= c_coxa_q;

      d_dd_q   <= c2s_d_q * c2s_d_q;
      d_aa_q   <= a_len * a_len;
      d_bb_q   <= b_len * b_len;
      d_ab_q   <= a_len * b_len;
      d_bd_q   <= b_len * c2s_d_q;
      d_oor_q  <= c2s_oor_q;
      d_fi_q   <= c2s_fi_q;
      d_coxa_q <= c2s_coxa_q;

      e_pa_q   <= $signed(PW'(d_bb_q)) + $signed(PW'(d_dd_q)) - $signed(PW'(d_aa_q));
      e_qa_q   <= PW'(d_bd_q) << 1;
      e_pg_q   <= $signed(PW'(d_aa_q)) + $signed(PW'(d_bb_q)) - $signed(PW'(d_dd_q));
      e_qg_q   <= PW'(d_ab_q) << 1;
      e_oor_q  <= d_oor_q;
      e_fi_q   <= d_fi_q;
      e_coxa_q <= d_coxa_q;
    end
  end

  // law of cosines: alpha at the femur, gamma at the knee
  logic                  va, vg;
  acos_res_t             alpha, gamma;
  logic [AW:0]           sba;
  logic [AW-1:0]         sbg;
  logic                  f_oor;
  logic signed [AW-1:0]  f_fi;

  tjl_acos #(
    .STEPS (CORDIC_STEPS),
    .SB_W  (AW + 1)
  ) u_acos_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_v_q),
    .p_i     (e_pa_q),
    .q_i     (e_qa_q),
    .sb_i    ({e_oor_q, e_fi_q}),
    .valid_o (va),
    .res_o   (alpha),
    .sb_o    (sba)
  );

  tjl_acos #(
    .STEPS (CORDIC_STEPS),
    .SB_W  (AW)
  ) u_acos_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_v_q),
    .p_i     (e_pg_q),
    .q_i     (e_qg_q),
    .sb_i    (e_coxa_q),
    .valid_o (vg),
    .res_o   (gamma),
    .sb_o    (sbg)
  );

  assign {f_oor, f_fi} = sba;

  // output stage
  logic signed [RW-1:0] femur_q16, tibia_q16, coxa_rnd, femur_rnd, tibia_rnd;
  status_e              st;

  always_comb begin
    femur_q16 = (RW'(femur_zero_q) <<< 16) - RW'(alpha.angle) - RW'(f_fi);
    tibia_q16 = RW'(gamma.angle) - (RW'(tibia_zero_q) <<< 16);
    if (f_oor) begin
      femur_q16 = '0;
      tibia_q16 = '0;
    end
    coxa_rnd  = round_q16(RW'($signed(sbg)));
    femur_rnd = round_q16(femur_q16);
    tibia_rnd = round_q16(tibia_q16);
    if (f_oor) begin
      st = ST_OUT_OF_REACH;
    end else if (alpha.clamp || gamma.clamp) begin
      st = ST_TOO_CLOSE;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q   <= 1'b0;
      b2_v_q  <= 1'b0;
      c_v_q   <= 1'b0;
      c2s_v_q <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b_v_q   <= c1_v;
      b2_v_q  <= b_v_q;
      c_v_q   <= c2_v;
      c2s_v_q <= c_v_q;
      d_v_q   <= c2s_v_q;
      e_v_q   <= d_v_q;
      out_v_q <= va;
    end
  end

  logic signed [COXA_OUT_W-1:0]  coxa_out_q;
  logic signed [JOINT_OUT_W-1:0] femur_out_q, tibia_out_q;
  logic [STATUS_W-1:0]           status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      coxa_out_q  <= coxa_rnd[COXA_OUT_W-1:0];
      femur_out_q <= femur_rnd[JOINT_OUT_W-1:0];
      tibia_out_q <= tibia_rnd[JOINT_OUT_W-1:0];
      status_q    <= st;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.coxa_angle  = coxa_out_q;
  assign res_o.femur_angle = femur_out_q;
  assign res_o.tibia_angle = tibia_out_q;
  assign res_o.status      = status_q;

  // both acos lanes carry the same beats
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va == vg) else $error("acos lanes out of step");

  a_reach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == ST_OUT_OF_REACH) |->
      (res_o.femur_angle == '0) && (res_o.tibia_angle == '0))
    else $error("out of reach result carries joint angles");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> tgt_i.ready) else $error("input stalled with empty output");

endmodule
